>>> src/etd_pkg.sv
// etd_pkg: shared types, field widths, register map and status codes
// for the echo thickness detector. No dependencies.

package etd_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int THR_W       = 16;
    localparam int GATE_W      = 14;
    localparam int SPEED_W     = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 15;
    localparam int PROD_W      = COUNT_W + SPEED_W;
    localparam int THICK_W     = 36;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int THICK_SCALE = 25;

    // Default record capacity and result queue depth
    localparam int RECORD_CAPACITY = 16384;
    localparam int QUEUE_DEPTH     = 4;

    // Measurement modes
    localparam logic [MODE_W-1:0] MODE_CROSSING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GATES    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_THRESHOLD  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CROSSING   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GATE_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_GATE_REVERSED = 3'd4;

    // Register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_G1_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_G1_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_G2_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_G2_END     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_OFFS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd7;

    // Register reset values
    localparam logic [MODE_W-1:0]       RST_MODE       = MODE_CROSSING;
    localparam logic signed [THR_W-1:0] RST_THRESHOLD  = 16'sd600;
    localparam logic [GATE_W-1:0]       RST_G1_START   = 14'd20;
    localparam logic [GATE_W-1:0]       RST_G1_END     = 14'd120;
    localparam logic [GATE_W-1:0]       RST_G2_START   = 14'd140;
    localparam logic [GATE_W-1:0]       RST_G2_END     = 14'd240;
    localparam logic [GATE_W-1:0]       RST_PROBE_OFFS = 14'd400;
    localparam logic [SPEED_W-1:0]      RST_SPEED      = 16'd3200;

    // Input beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          record_end;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  sample_count;
        logic [THICK_W-1:0]  thickness;
    } t_out;

    // Configuration register file
    typedef struct packed {
        logic [MODE_W-1:0]       mode_select;
        logic signed [THR_W-1:0] crossing_threshold;
        logic [GATE_W-1:0]       gate_one_start;
        logic [GATE_W-1:0]       gate_one_end;
        logic [GATE_W-1:0]       gate_two_start;
        logic [GATE_W-1:0]       gate_two_end;
        logic [GATE_W-1:0]       probe_offset;
        logic [SPEED_W-1:0]      sound_speed;
    } t_cfg;

    // Classified record result handed from front to back
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_job;

    // Queue status flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Zero-crossing search phase
    typedef enum logic [2:0] {
        PH_SEEK  = 3'b001,
        PH_CROSS = 3'b010,
        PH_FOUND = 3'b100
    } t_phase;

endpackage

>>> src/etd_front.sv
// etd_front: per-sample search front end. Tracks the zero-crossing search and
// both gate peaks, and classifies each record at its end. Uses etd_pkg.

module etd_front #(
    parameter int RECORD_CAPACITY = etd_pkg::RECORD_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  etd_pkg::t_in  i_item,
    input  etd_pkg::t_cfg i_cfg,
    output logic          o_push,
    output etd_pkg::t_job o_job
);

    localparam int POS_W = $clog2(RECORD_CAPACITY);
    localparam int CMP_W = ((POS_W > etd_pkg::GATE_W) ? POS_W : etd_pkg::GATE_W) + 1;
    localparam logic [POS_W:0] CAP = (POS_W + 1)'(RECORD_CAPACITY);

    // Record state
    logic [POS_W-1:0]                       r_pos, a_pos, n_pos;
    logic                                   r_sat, a_sat, n_sat;
    etd_pkg::t_phase                        r_phase, a_phase, n_phase;
    logic                                   r_ref_sign, a_ref_sign, n_ref_sign;
    logic [POS_W-1:0]                       r_cross_pos, a_cross_pos, n_cross_pos;
    logic signed [etd_pkg::SAMPLE_BITS-1:0] r_peak1, a_peak1, n_peak1;
    logic [POS_W-1:0]                       r_p1_pos, a_p1_pos, n_p1_pos;
    logic                                   r_seen1, a_seen1, n_seen1;
    logic signed [etd_pkg::SAMPLE_BITS-1:0] r_peak2, a_peak2, n_peak2;
    logic [POS_W-1:0]                       r_p2_pos, a_p2_pos, n_p2_pos;
    logic                                   r_seen2, a_seen2, n_seen2;

    logic             sign;
    logic [CMP_W-1:0] pos_ext;
    logic             in_gate1, in_gate2;
    logic [CMP_W-1:0] cross_sum, gate_diff, raw_count;

    assign sign     = ~i_item.sample[etd_pkg::SAMPLE_BITS-1];
    assign pos_ext  = CMP_W'(r_pos);
    assign in_gate1 = (pos_ext >= CMP_W'(i_cfg.gate_one_start)) &&
                      (pos_ext <= CMP_W'(i_cfg.gate_one_end));
    assign in_gate2 = (pos_ext >= CMP_W'(i_cfg.gate_two_start)) &&
                      (pos_ext <= CMP_W'(i_cfg.gate_two_end));

    // Apply the accepted sample to the searches
    always_comb begin
        a_pos       = r_pos;
        a_sat       = r_sat;
        a_phase     = r_phase;
        a_ref_sign  = r_ref_sign;
        a_cross_pos = r_cross_pos;
        a_peak1     = r_peak1;
        a_p1_pos    = r_p1_pos;
        a_seen1     = r_seen1;
        a_peak2     = r_peak2;
        a_p2_pos    = r_p2_pos;
        a_seen2     = r_seen2;
        if (i_take && !r_sat) begin
            unique case (r_phase)
                etd_pkg::PH_SEEK: begin
                    if (i_item.sample >= i_cfg.crossing_threshold) begin
                        a_phase    = etd_pkg::PH_CROSS;
                        a_ref_sign = sign;
                    end
                end
                etd_pkg::PH_CROSS: begin
                    if (sign != r_ref_sign) begin
                        a_cross_pos = r_pos;
                        a_phase     = etd_pkg::PH_FOUND;
                    end
                end
                default: begin
                    a_phase = r_phase;
                end
            endcase
            if (in_gate1 && (!r_seen1 || (i_item.sample > r_peak1))) begin
                a_peak1  = i_item.sample;
                a_p1_pos = r_pos;
                a_seen1  = 1'b1;
            end
            if (in_gate2 && (!r_seen2 || (i_item.sample > r_peak2))) begin
                a_peak2  = i_item.sample;
                a_p2_pos = r_pos;
                a_seen2  = 1'b1;
            end
            if (({1'b0, r_pos} + 1'b1) >= CAP) begin
                a_sat = 1'b1;
            end else begin
                a_pos = r_pos + 1'b1;
            end
        end
    end

    // Classify the record on its final beat
    assign cross_sum = CMP_W'(a_cross_pos) + CMP_W'(i_cfg.probe_offset);
    assign gate_diff = CMP_W'(a_p2_pos) - CMP_W'(a_p1_pos);

    always_comb begin
        o_push       = 1'b0;
        o_job.status = etd_pkg::ST_OK;
        raw_count    = '0;
        case (i_cfg.mode_select)
            etd_pkg::MODE_CROSSING: begin
                o_push = i_take && i_item.record_end;
                if (a_phase == etd_pkg::PH_SEEK) begin
                    o_job.status = etd_pkg::ST_NO_THRESHOLD;
                end else if (a_phase == etd_pkg::PH_CROSS) begin
                    o_job.status = etd_pkg::ST_NO_CROSSING;
                end else begin
                    raw_count = cross_sum;
                end
            end
            etd_pkg::MODE_GATES: begin
                o_push = i_take && i_item.record_end;
                if (!a_seen1 || !a_seen2) begin
                    o_job.status = etd_pkg::ST_GATE_EMPTY;
                end else if (a_p2_pos < a_p1_pos) begin
                    o_job.status = etd_pkg::ST_GATE_REVERSED;
                end else begin
                    raw_count = gate_diff;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
        if (raw_count > CMP_W'(etd_pkg::COUNT_MAX)) begin
            o_job.count = etd_pkg::COUNT_MAX;
        end else begin
            o_job.count = raw_count[etd_pkg::COUNT_W-1:0];
        end
    end

    // Drop the record state after its final beat
    always_comb begin
        if (i_take && i_item.record_end) begin
            n_pos       = '0;
            n_sat       = 1'b0;
            n_phase     = etd_pkg::PH_SEEK;
            n_ref_sign  = 1'b0;
            n_cross_pos = '0;
            n_peak1     = '0;
            n_p1_pos    = '0;
            n_seen1     = 1'b0;
            n_peak2     = '0;
            n_p2_pos    = '0;
            n_seen2     = 1'b0;
        end else begin
            n_pos       = a_pos;
            n_sat       = a_sat;
            n_phase     = a_phase;
            n_ref_sign  = a_ref_sign;
            n_cross_pos = a_cross_pos;
            n_peak1     = a_peak1;
            n_p1_pos    = a_p1_pos;
            n_seen1     = a_seen1;
            n_peak2     = a_peak2;
            n_p2_pos    = a_p2_pos;
            n_seen2     = a_seen2;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sat      <= 1'b0;
            r_phase    <= etd_pkg::PH_SEEK;
            r_ref_sign <= 1'b0;
            r_seen1    <= 1'b0;
            r_seen2    <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_sat      <= n_sat;
            r_phase    <= n_phase;
            r_ref_sign <= n_ref_sign;
            r_seen1    <= n_seen1;
            r_seen2    <= n_seen2;
        end
    end

    // Peak and crossing payload, qualified by phase and seen flags
    always_ff @(posedge i_clk) begin
        r_cross_pos <= n_cross_pos;
        r_peak1     <= n_peak1;
        r_p1_pos    <= n_p1_pos;
        r_peak2     <= n_peak2;
        r_p2_pos    <= n_p2_pos;
    end

endmodule

>>> src/etd_queue.sv
// etd_queue: short FIFO of classified record results between the front
// and back ends. Uses etd_pkg.

module etd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  etd_pkg::t_job      i_job,
    input  logic               i_pop,
    output etd_pkg::t_job      o_head,
    output etd_pkg::t_q_status o_status
);

    localparam int DEPTH = etd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    etd_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_fill;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_fill == CNT_W'(DEPTH));
    assign o_status.empty  = (r_fill == '0);

    // Write entry at tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> src/etd_back.sv
// etd_back: thickness scaling back end. Multiplies count by sound speed,
// then by the fixed scale, into the output register. Uses etd_pkg.

module etd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  etd_pkg::t_job                  i_head,
    input  etd_pkg::t_q_status             i_q_status,
    input  logic [etd_pkg::SPEED_W-1:0]    i_speed,
    input  logic                           i_stall,
    output logic                           o_pop,
    output logic                           o_valid,
    output etd_pkg::t_out                  o_data
);

    logic                           r_s1_valid;
    logic [etd_pkg::STATUS_W-1:0]   r_s1_status;
    logic [etd_pkg::COUNT_W-1:0]    r_s1_count;
    logic [etd_pkg::PROD_W-1:0]     r_s1_prod;
    logic                           r_out_valid;
    etd_pkg::t_out                  r_out;
    logic                           out_free, s1_free;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = !i_q_status.empty && s1_free;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= !i_q_status.empty;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Stage one: count times speed
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_status <= i_head.status;
            r_s1_count  <= i_head.count;
            r_s1_prod   <= etd_pkg::PROD_W'(i_head.count) * etd_pkg::PROD_W'(i_speed);
        end
    end

    // Stage two: apply the fixed scale into the output register
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out.status       <= r_s1_status;
            r_out.sample_count <= r_s1_count;
            r_out.thickness    <= etd_pkg::THICK_W'(r_s1_prod) *
                                  etd_pkg::THICK_W'(etd_pkg::THICK_SCALE);
        end
    end

endmodule

>>> src/echo_thickness_detector.sv
// echo_thickness_detector: top level. Holds the register file and joins the
// front end, result queue and back end. Uses etd_pkg, etd_front, etd_queue, etd_back.
//
//   channel  direction  handshake                   beat
//   in       sink       i_in_valid / o_in_stall     t_in  (sample, record_end)
//   out      source     o_out_valid / i_out_stall   t_out (status, count, thickness)
//   cfg      sink       i_cfg_valid / o_cfg_ready   index + data
//
// One sample beat per cycle while o_in_stall is low. A result reaches the output register
// through the queue write, which shares the edge of the record_end beat, then the speed
// multiply, then the scale multiply into the output register.
// o_in_stall rises only when the four-entry result queue is full.
// Synchronous active-low reset loads register defaults and empties the pipeline.
// Configuration writes are always ready.

module echo_thickness_detector #(
    parameter int RECORD_CAPACITY = etd_pkg::RECORD_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  etd_pkg::t_in                      i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output etd_pkg::t_out                     o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [etd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [etd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    etd_pkg::t_cfg      r_cfg;
    etd_pkg::t_job      w_job, w_head;
    etd_pkg::t_q_status w_q_status;
    logic               w_take, w_push, w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_status.full;
    assign w_take      = i_in_valid && !w_q_status.full;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_select        <= etd_pkg::RST_MODE;
            r_cfg.crossing_threshold <= etd_pkg::RST_THRESHOLD;
            r_cfg.gate_one_start     <= etd_pkg::RST_G1_START;
            r_cfg.gate_one_end       <= etd_pkg::RST_G1_END;
            r_cfg.gate_two_start     <= etd_pkg::RST_G2_START;
            r_cfg.gate_two_end       <= etd_pkg::RST_G2_END;
            r_cfg.probe_offset       <= etd_pkg::RST_PROBE_OFFS;
            r_cfg.sound_speed        <= etd_pkg::RST_SPEED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                etd_pkg::CFG_MODE: begin
                    r_cfg.mode_select <= i_cfg_data[etd_pkg::MODE_W-1:0];
                end
                etd_pkg::CFG_THRESHOLD: begin
                    r_cfg.crossing_threshold <= i_cfg_data[etd_pkg::THR_W-1:0];
                end
                etd_pkg::CFG_G1_START: begin
                    r_cfg.gate_one_start <= i_cfg_data[etd_pkg::GATE_W-1:0];
                end
                etd_pkg::CFG_G1_END: begin
                    r_cfg.gate_one_end <= i_cfg_data[etd_pkg::GATE_W-1:0];
                end
                etd_pkg::CFG_G2_START: begin
                    r_cfg.gate_two_start <= i_cfg_data[etd_pkg::GATE_W-1:0];
                end
                etd_pkg::CFG_G2_END: begin
                    r_cfg.gate_two_end <= i_cfg_data[etd_pkg::GATE_W-1:0];
                end
                etd_pkg::CFG_PROBE_OFFS: begin
                    r_cfg.probe_offset <= i_cfg_data[etd_pkg::GATE_W-1:0];
                end
                etd_pkg::CFG_SPEED: begin
                    r_cfg.sound_speed <= i_cfg_data[etd_pkg::SPEED_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    etd_front #(
        .RECORD_CAPACITY(RECORD_CAPACITY)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    etd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    etd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .i_speed    (r_cfg.sound_speed),
        .i_stall    (i_out_stall),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data)
    );

    // The front never writes a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("result written into full queue");

    // The back never reads an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("result read from empty queue");

    // An error result carries no count and no thickness
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != etd_pkg::ST_OK)) |->
        ((o_out_data.sample_count == '0) && (o_out_data.thickness == '0)))
        else $error("error result with nonzero count");

    // Reset empties the output stage
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for echo_thickness_detector. Streams A-scan records,
// predicts each thickness reading on its own and compares every output beat.
// Depends on etd_pkg and the echo_thickness_detector RTL only.
`timescale 1ns / 1ps

import etd_pkg::*;

// Tracks record state and configuration, and holds the readings still due
class reading_board;
    int mode, thr, g1_start, g1_end, g2_start, g2_end, probe, speed;
    int pos, cross_pos, g1_peak, g1_at, g2_peak, g2_at;
    int capacity;
    bit full_rec, ref_nonneg, g1_seen, g2_seen;
    t_phase phase;
    t_out due_readings[$];
    int errors;

    function new(int cap);
        capacity = cap;
        mode = RST_MODE;
        thr = RST_THRESHOLD;
        g1_start = RST_G1_START;
        g1_end = RST_G1_END;
        g2_start = RST_G2_START;
        g2_end = RST_G2_END;
        probe = RST_PROBE_OFFS;
        speed = RST_SPEED;
        errors = 0;
        clear_record();
    endfunction

    function void clear_record();
        pos = 0;
        full_rec = 0;
        phase = PH_SEEK;
        ref_nonneg = 0;
        cross_pos = 0;
        g1_peak = 0;
        g1_at = 0;
        g1_seen = 0;
        g2_peak = 0;
        g2_at = 0;
        g2_seen = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE:       mode = data[MODE_W-1:0];
            CFG_THRESHOLD:  thr = $signed(data[THR_W-1:0]);
            CFG_G1_START:   g1_start = data[GATE_W-1:0];
            CFG_G1_END:     g1_end = data[GATE_W-1:0];
            CFG_G2_START:   g2_start = data[GATE_W-1:0];
            CFG_G2_END:     g2_end = data[GATE_W-1:0];
            CFG_PROBE_OFFS: probe = data[GATE_W-1:0];
            CFG_SPEED:      speed = data[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the record by one sample beat; queue a reading on record end
    function void take_sample(t_in b);
        int s, i, count;
        bit nonneg, emit;
        logic [STATUS_W-1:0] st;
        longint prod;
        t_out r;
        s = $signed(b.sample);
        i = pos;
        nonneg = (s >= 0);
        // drop samples past the record capacity
        if (!full_rec) begin
            case (phase)
                PH_SEEK: if (s >= thr) begin
                    phase = PH_CROSS;
                    ref_nonneg = nonneg;
                end
                PH_CROSS: if (nonneg != ref_nonneg) begin
                    cross_pos = i;
                    phase = PH_FOUND;
                end
                default: ;
            endcase
            if (i >= g1_start && i <= g1_end && (!g1_seen || s > g1_peak)) begin
                g1_peak = s;
                g1_at = i;
                g1_seen = 1;
            end
            if (i >= g2_start && i <= g2_end && (!g2_seen || s > g2_peak)) begin
                g2_peak = s;
                g2_at = i;
                g2_seen = 1;
            end
            if (i + 1 >= capacity)
                full_rec = 1;
            else
                pos = i + 1;
        end
        if (!b.record_end)
            return;

        // classify the record
        st = ST_OK;
        count = 0;
        emit = 0;
        if (mode == MODE_CROSSING) begin
            emit = 1;
            if (phase == PH_SEEK)
                st = ST_NO_THRESHOLD;
            else if (phase == PH_CROSS)
                st = ST_NO_CROSSING;
            else
                count = cross_pos + probe;
        end else if (mode == MODE_GATES) begin
            emit = 1;
            if (!g1_seen || !g2_seen)
                st = ST_GATE_EMPTY;
            else if (g2_at < g1_at)
                st = ST_GATE_REVERSED;
            else
                count = g2_at - g1_at;
        end
        clear_record();
        if (!emit)
            return;
        if (count > int'(COUNT_MAX))
            count = int'(COUNT_MAX);
        prod = longint'(count) * longint'(speed) * THICK_SCALE;
        r.status = st;
        r.sample_count = count[COUNT_W-1:0];
        r.thickness = prod[THICK_W-1:0];
        due_readings.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one output beat with the oldest reading due
    task check_reading(t_out got);
        t_out want;
        if (due_readings.size() == 0) begin
            report("reading with none due");
            return;
        end
        want = due_readings.pop_front();
        if (got.status != want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.sample_count != want.sample_count)
            report($sformatf("sample_count %0d, want %0d",
                             got.sample_count, want.sample_count));
        if (got.thickness != want.thickness)
            report($sformatf("thickness %0d, want %0d", got.thickness, want.thickness));
    endtask

    function int outstanding();
        return due_readings.size();
    endfunction
endclass

module tb_top;

    localparam int RANDOM_SAMPLES = 1100;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int QUIET_LIMIT    = 3000;
    // short record capacity keeps the overlong record brief
    localparam int TB_CAPACITY    = 64;

    // mode codes that produce no reading
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in                   i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    reading_board readings;
    int rec_q[$];
    logic [CFG_IDX_W-1:0]  pend_idx[$];
    logic [CFG_DATA_W-1:0] pend_val[$];
    int samples_sent = 0;
    int burst_left = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int quiet_cycles = 0;

    echo_thickness_detector #(
        .RECORD_CAPACITY(TB_CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sample all three channels on the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                readings.check_reading(o_out_data);
            if (i_in_valid && !o_in_stall)
                readings.take_sample(i_in_data);
            if (i_cfg_valid && o_cfg_ready)
                readings.write_register(i_cfg_index, i_cfg_data);
        end
    end

    // End the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall in runs of varying density, or hold off long when asked
    initial begin : receiver
        int n, style;
        forever begin
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                style = $urandom_range(0, 3);
                n = $urandom_range(1, 60);
                repeat (n) begin
                    case (style)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 3) == 0);
                        2: i_out_stall <= 1'($urandom_range(0, 1));
                        default: i_out_stall <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offer one sample beat and hold it until taken; may idle between bursts
    task automatic send_beat(t_in b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    // Stream rec_q as one record, end mark on the last sample
    task automatic send_record();
        t_in b;
        for (int k = 0; k < rec_q.size(); k++) begin
            b.sample = 16'(rec_q[k]);
            b.record_end = (k == rec_q.size() - 1);
            send_beat(b);
        end
    endtask

    // Drop valid, let the last beat reach the board, wait for every reading due
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (readings.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stage(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        pend_idx.push_back(idx);
        pend_val.push_back(val);
    endtask

    // Write all staged registers once the block is idle
    task automatic apply_settings();
        wait_idle();
        while (pend_idx.size() > 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= pend_idx.pop_front();
            i_cfg_data <= pend_val.pop_front();
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gate();
        case ($urandom_range(0, 9))
            0: return 16383;
            1: return 0;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic int pick_sample(int style, int prev);
        int v;
        case (style)
            0: begin
                v = $urandom_range(0, 65535);
                return v - 32768;
            end
            1: begin
                v = $urandom_range(0, 40);
                return v - 20;
            end
            2: case ($urandom_range(0, 3))
                0: return -32768;
                1: return 32767;
                2: return 0;
                default: return -1;
            endcase
            3: begin
                // plateaus so that equal peaks compete
                if ($urandom_range(0, 2) != 0)
                    return prev;
                v = $urandom_range(0, 200);
                return v - 100;
            end
            default: begin
                v = $urandom_range(0, 1200);
                return v - 600;
            end
        endcase
    endfunction

    initial begin : stimulus
        int v, len, style, prev, nrec, base;
        readings = new(TB_CAPACITY);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: crossing mode, threshold 600, probe 400
        rec_q = '{700, -1};
        send_record();

        // Crossing found, threshold never reached, no crossing
        stage(CFG_MODE, 16'(MODE_CROSSING));
        stage(CFG_THRESHOLD, 16'd10);
        stage(CFG_PROBE_OFFS, 16'd0);
        stage(CFG_SPEED, 16'd65535);
        apply_settings();
        rec_q = '{5, 20, -3};
        send_record();
        rec_q = '{0, 1};
        send_record();
        rec_q = '{50, 60};
        send_record();

        // Lowest threshold arms on a negative sample; speed zero
        stage(CFG_THRESHOLD, 16'h8000);
        stage(CFG_PROBE_OFFS, 16'd16383);
        stage(CFG_SPEED, 16'd0);
        apply_settings();
        rec_q = '{-32768, -1, 0};
        send_record();

        // Highest threshold needs the top sample value
        stage(CFG_THRESHOLD, 16'h7FFF);
        stage(CFG_SPEED, 16'd1);
        apply_settings();
        rec_q = '{32766, 32767, -32768};
        send_record();

        // Two gates: first maximum wins, then an empty second gate
        stage(CFG_MODE, 16'(MODE_GATES));
        stage(CFG_G1_START, 16'd0);
        stage(CFG_G1_END, 16'd2);
        stage(CFG_G2_START, 16'd3);
        stage(CFG_G2_END, 16'd5);
        stage(CFG_SPEED, 16'd3200);
        apply_settings();
        rec_q = '{1, 7, 7, 9, 9, 2};
        send_record();
        rec_q = '{3};
        send_record();

        // Second peak ahead of the first
        stage(CFG_G1_START, 16'd3);
        stage(CFG_G1_END, 16'd5);
        stage(CFG_G2_START, 16'd0);
        stage(CFG_G2_END, 16'd2);
        apply_settings();
        rec_q = '{5, -2, 0, 9, 5, 1};
        send_record();

        // Inverted gate holds nothing
        stage(CFG_G1_START, 16'd4);
        stage(CFG_G1_END, 16'd1);
        apply_settings();
        rec_q = '{1, 2};
        send_record();

        // Unused modes close the record without a reading
        stage(CFG_MODE, 16'(MODE_UNUSED_LO));
        apply_settings();
        rec_q = '{4};
        send_record();
        stage(CFG_MODE, 16'(MODE_UNUSED_HI));
        apply_settings();
        rec_q = '{4};
        send_record();

        // Overlong record: crossing at index 6, gate two peak at the second-to-last index, tail ignored
        rec_q.delete();
        for (int i = 0; i < TB_CAPACITY + 20; i++) begin
            if (i >= TB_CAPACITY)
                v = 32767;
            else if (i == 5)
                v = 1000;
            else if (i == TB_CAPACITY - 2)
                v = 30000;
            else if (i == TB_CAPACITY - 1)
                v = -1;
            else
                v = -5;
            rec_q.push_back(v);
        end
        stage(CFG_MODE, 16'(MODE_CROSSING));
        stage(CFG_THRESHOLD, 16'd100);
        stage(CFG_PROBE_OFFS, 16'd16383);
        stage(CFG_SPEED, 16'd65535);
        stage(CFG_G1_START, 16'd0);
        stage(CFG_G1_END, 16'd10);
        stage(CFG_G2_START, 16'(TB_CAPACITY - 4));
        stage(CFG_G2_END, 16'(TB_CAPACITY - 1));
        apply_settings();
        send_record();
        stage(CFG_MODE, 16'(MODE_GATES));
        apply_settings();
        send_record();

        // Long receiver hold-off while short records keep coming
        stage(CFG_MODE, 16'(MODE_CROSSING));
        stage(CFG_THRESHOLD, 16'h8000);
        apply_settings();
        hold_asked++;
        wait (hold_served == hold_asked);
        repeat (24) begin
            rec_q.delete();
            len = $urandom_range(1, 2);
            repeat (len) rec_q.push_back(pick_sample(0, 0));
            send_record();
        end

        // Random settings, each followed by a handful of records
        base = samples_sent;
        while (samples_sent - base < RANDOM_SAMPLES) begin
            v = $urandom_range(0, 19);
            if (v == 0)
                stage(CFG_MODE, 16'(MODE_UNUSED_LO));
            else if (v == 1)
                stage(CFG_MODE, 16'(MODE_UNUSED_HI));
            else if (v < 11)
                stage(CFG_MODE, 16'(MODE_CROSSING));
            else
                stage(CFG_MODE, 16'(MODE_GATES));
            case ($urandom_range(0, 7))
                0: stage(CFG_THRESHOLD, 16'h8000);
                1: stage(CFG_THRESHOLD, 16'h7FFF);
                2: stage(CFG_THRESHOLD, 16'($urandom()));
                default: begin
                    v = $urandom_range(0, 600);
                    stage(CFG_THRESHOLD, 16'(v - 300));
                end
            endcase
            stage(CFG_G1_START, 16'(pick_gate()));
            stage(CFG_G1_END, 16'(pick_gate()));
            stage(CFG_G2_START, 16'(pick_gate()));
            stage(CFG_G2_END, 16'(pick_gate()));
            case ($urandom_range(0, 5))
                0: stage(CFG_PROBE_OFFS, 16'd0);
                1: stage(CFG_PROBE_OFFS, 16'd16383);
                default: stage(CFG_PROBE_OFFS, 16'($urandom_range(0, 16383)));
            endcase
            case ($urandom_range(0, 5))
                0: stage(CFG_SPEED, 16'd0);
                1: stage(CFG_SPEED, 16'd65535);
                default: stage(CFG_SPEED, 16'($urandom()));
            endcase
            apply_settings();

            nrec = $urandom_range(3, 8);
            repeat (nrec) begin
                rec_q.delete();
                len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
                style = $urandom_range(0, 5);
                prev = 0;
                repeat (len) begin
                    v = pick_sample((style == 5) ? $urandom_range(0, 4) : style, prev);
                    rec_q.push_back(v);
                    prev = v;
                end
                send_record();
            end
        end

        wait_idle();
        if (readings.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> echo_thickness_detector.f
src/etd_pkg.sv
src/etd_front.sv
src/etd_queue.sv
src/etd_back.sv
src/echo_thickness_detector.sv
bench/tb_top.sv
